// File: rtl/bca_pkg.sv
// bca_pkg: shared types, link codes, status codes and reset helpers
// for the buddy context allocator; no dependencies
`default_nettype none

package bca_pkg;

	// link map entry codes
	localparam int unsigned LINK_W = 9;
	localparam logic [LINK_W-1:0] NIL_LINK  = 9'h1FF;
	localparam logic [LINK_W-1:0] BUSY_LINK = 9'h1FE;

	// free blocks placed by reset
	localparam int unsigned LOW_BLOCK  = 'h00;
	localparam int unsigned LOW_ORDER  = 5;
	localparam int unsigned HIGH_BLOCK = 'h40;
	localparam int unsigned HIGH_ORDER = 6;

	// parameter defaults
	localparam int unsigned NUM_CONTEXTS_DEF           = 128;
	localparam int unsigned MAX_ORDER_DEF              = 7;
	localparam int unsigned PAGES_PER_CONTEXT_LOG2_DEF = 4;

	localparam logic [15:0] WHOLE_MAP_LIMIT_RST = 16'd1024;

	// opcodes
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_FREE  = 1'b1;

	// status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NO_FREE = 2'd1;
	localparam logic [1:0] ST_TOO_BIG = 2'd2;
	localparam logic [1:0] ST_CORRUPT = 2'd3;

	typedef struct packed {
		logic        opcode;
		logic [15:0] request_pages;
		logic [6:0]  free_block;
		logic [2:0]  free_order;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [6:0] block_number;
		logic [2:0] block_order;
	} rsp_t;

	// link memory command
	typedef struct packed {
		logic              rd_en;
		logic              wr_en;
		logic [LINK_W-1:0] wdata;
	} lm_cmd_t;

	// true when a reset block fits the map
	function automatic logic blk_placed(int unsigned blk, int unsigned ord,
			int unsigned num_ctx, int unsigned max_ord);
		return (ord <= max_ord) && (blk + (1 << ord) <= num_ctx);
	endfunction

	// link map contents after reset
	function automatic logic [LINK_W-1:0] link_rst_val(int unsigned idx,
			int unsigned num_ctx, int unsigned max_ord);
		logic hit;
		hit = (idx == LOW_BLOCK && blk_placed(LOW_BLOCK, LOW_ORDER, num_ctx, max_ord))
			|| (idx == HIGH_BLOCK && blk_placed(HIGH_BLOCK, HIGH_ORDER, num_ctx, max_ord));
		return hit ? NIL_LINK : BUSY_LINK;
	endfunction

endpackage

`default_nettype wire

// File: rtl/bca_link_ram.sv
// bca_link_ram: link map storage, one access per cycle, registered read
// per-entry valid bits give the reset contents; depends on bca_pkg
`default_nettype none

module bca_link_ram import bca_pkg::*; #(
	parameter int unsigned DEPTH     = NUM_CONTEXTS_DEF,
	parameter int unsigned MAX_ORDER = MAX_ORDER_DEF,
	localparam int unsigned AW = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire lm_cmd_t           cmd,
	input  wire logic [AW-1:0]     addr,
	output      logic [LINK_W-1:0] rdata
);

	logic [LINK_W-1:0] mem [DEPTH];
	logic [DEPTH-1:0]  vld_q;
	logic [LINK_W-1:0] rd_data_q;
	logic [LINK_W-1:0] rd_rst_q;
	logic              rd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (cmd.wr_en) begin
			vld_q[addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[addr] <= cmd.wdata;
		end
		if (cmd.rd_en) begin
			rd_data_q <= mem[addr];
			rd_vld_q  <= vld_q[addr];
			rd_rst_q  <= link_rst_val(int'(addr), DEPTH, MAX_ORDER);
		end
	end

	// never-written entries read as their reset value
	assign rdata = rd_vld_q ? rd_data_q : rd_rst_q;

endmodule

`default_nettype wire

// File: rtl/bca_seq.sv
// bca_seq: sequencer for allocate and free with the free-list heads
// drives the link memory port; depends on bca_pkg
`default_nettype none

module bca_seq import bca_pkg::*; #(
	parameter int unsigned NUM_CONTEXTS           = NUM_CONTEXTS_DEF,
	parameter int unsigned MAX_ORDER              = MAX_ORDER_DEF,
	parameter int unsigned PAGES_PER_CONTEXT_LOG2 = PAGES_PER_CONTEXT_LOG2_DEF,
	localparam int unsigned AW = $clog2(NUM_CONTEXTS)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	input  wire req_t              req,
	input  wire logic [15:0]       limit,
	output      logic              idle,
	output      logic              done,
	output      rsp_t              rsp,
	input  wire logic              take,
	output      lm_cmd_t           cmd,
	output      logic [AW-1:0]     addr,
	input  wire logic [LINK_W-1:0] rdata
);

	localparam int unsigned HW     = $clog2(MAX_ORDER + 1);
	localparam int unsigned CTX_W  = 17 - PAGES_PER_CONTEXT_LOG2;
	localparam int unsigned STEP_W = $clog2(NUM_CONTEXTS + 3);
	localparam logic [9:0]  NUM_L  = 10'(NUM_CONTEXTS);
	localparam logic [16:0] PG_MASK = 17'((1 << PAGES_PER_CONTEXT_LOG2) - 1);
	localparam logic [4:0]  MAXO_L = 5'(MAX_ORDER);
	localparam logic [STEP_W-1:0] STEP_LIM = STEP_W'(NUM_CONTEXTS + 1);
	localparam logic LOW_OK  = blk_placed(LOW_BLOCK, LOW_ORDER, NUM_CONTEXTS, MAX_ORDER);
	localparam logic HIGH_OK = blk_placed(HIGH_BLOCK, HIGH_ORDER, NUM_CONTEXTS, MAX_ORDER);

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_A_ORD   = 4'd1;
	localparam logic [3:0] S_A_SCAN  = 4'd2;
	localparam logic [3:0] S_A_POP   = 4'd3;
	localparam logic [3:0] S_A_SPLIT = 4'd4;
	localparam logic [3:0] S_F_TOP   = 4'd5;
	localparam logic [3:0] S_F_BCHK  = 4'd6;
	localparam logic [3:0] S_F_WALK  = 4'd7;
	localparam logic [3:0] S_F_WCHK  = 4'd8;
	localparam logic [3:0] S_F_LINK  = 4'd9;
	localparam logic [3:0] S_DONE    = 4'd10;

	logic [3:0]        state_q, state_d;
	logic [CTX_W-1:0]  ctx_q, ctx_d;
	logic [4:0]        order_q, order_d;
	logic [HW-1:0]     slot_q, slot_d;
	logic [LINK_W-1:0] num_q, num_d;
	logic [LINK_W-1:0] buddy_q, buddy_d;
	logic [LINK_W-1:0] bud_link_q, bud_link_d;
	logic [LINK_W-1:0] prev_q, prev_d;
	logic [STEP_W-1:0] steps_q, steps_d;
	rsp_t              rsp_q, rsp_d;

	logic [LINK_W-1:0] heads_q [MAX_ORDER+1];
	logic              hw_en;
	logic [HW-1:0]     hw_idx;
	logic [LINK_W-1:0] hw_data;
	logic [HW-1:0]     hr_idx;
	logic [LINK_W-1:0] head_rd;

	logic [16:0]       psum;
	logic [17:0]       pow;
	logic [9:0]        head_end;
	logic [HW-1:0]     slot_dn;
	logic [LINK_W-1:0] split_num;
	logic [LINK_W-1:0] buddy;
	logic [STEP_W-1:0] steps_inc;

	// single head read port, index chosen by state
	always_comb begin
		if (state_q == S_A_SPLIT) begin
			hr_idx = slot_dn;
		end else if (state_q == S_A_SCAN || state_q == S_A_POP) begin
			hr_idx = slot_q;
		end else begin
			hr_idx = order_q[HW-1:0];
		end
	end
	assign head_rd = heads_q[hr_idx];

	assign psum      = 17'(req.request_pages) + PG_MASK;
	assign pow       = 18'd1 << order_q;
	assign head_end  = {1'b0, head_rd} + (10'd1 << slot_q);
	assign slot_dn   = slot_q - HW'(1);
	assign split_num = num_q + (9'd1 << slot_dn);
	assign buddy     = num_q ^ (9'd1 << order_q[HW-1:0]);
	assign steps_inc = steps_q + STEP_W'(1);

	always_comb begin
		state_d    = state_q;
		ctx_d      = ctx_q;
		order_d    = order_q;
		slot_d     = slot_q;
		num_d      = num_q;
		buddy_d    = buddy_q;
		bud_link_d = bud_link_q;
		prev_d     = prev_q;
		steps_d    = steps_q;
		rsp_d      = rsp_q;
		hw_en      = 1'b0;
		hw_idx     = order_q[HW-1:0];
		hw_data    = num_q;
		cmd        = '0;
		addr       = num_q[AW-1:0];

		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					rsp_d = '0;
					if (req.opcode == OP_ALLOC) begin
						if (req.request_pages > limit) begin
							rsp_d.status = ST_TOO_BIG;
							state_d      = S_DONE;
						end else begin
							ctx_d   = CTX_W'(psum >> PAGES_PER_CONTEXT_LOG2);
							order_d = '0;
							state_d = S_A_ORD;
						end
					end else if (10'(req.free_block) >= NUM_L
							|| 5'(req.free_order) >= MAXO_L) begin
						state_d = S_DONE;
					end else begin
						num_d   = 9'(req.free_block);
						order_d = 5'(req.free_order);
						state_d = S_F_TOP;
					end
				end
			end

			// round the context count up to a power of two
			S_A_ORD: begin
				if (pow < 18'(ctx_q) && order_q != 5'd31) begin
					order_d = order_q + 5'd1;
				end else if (order_q >= MAXO_L) begin
					rsp_d.status = ST_NO_FREE;
					state_d      = S_DONE;
				end else begin
					slot_d  = order_q[HW-1:0];
					state_d = S_A_SCAN;
				end
			end

			S_A_SCAN: begin
				if (head_rd == NIL_LINK) begin
					if (5'(slot_q) + 5'd1 == MAXO_L) begin
						rsp_d.status = ST_NO_FREE;
						state_d      = S_DONE;
					end else begin
						slot_d = slot_q + HW'(1);
					end
				end else if ({1'b0, head_rd} >= NUM_L || head_end > NUM_L) begin
					rsp_d.status = ST_CORRUPT;
					state_d      = S_DONE;
				end else begin
					num_d      = head_rd;
					cmd.rd_en  = 1'b1;
					addr       = head_rd[AW-1:0];
					state_d    = S_A_POP;
				end
			end

			S_A_POP: begin
				hw_en   = 1'b1;
				hw_idx  = slot_q;
				hw_data = rdata;
				state_d = S_A_SPLIT;
			end

			// give back upper halves one order at a time
			S_A_SPLIT: begin
				if (5'(slot_q) > order_q) begin
					cmd.wr_en = 1'b1;
					cmd.wdata = head_rd;
					addr      = split_num[AW-1:0];
					hw_en     = 1'b1;
					hw_idx    = slot_dn;
					hw_data   = split_num;
					slot_d    = slot_dn;
				end else begin
					cmd.wr_en          = 1'b1;
					cmd.wdata          = BUSY_LINK;
					rsp_d.status       = ST_OK;
					rsp_d.block_number = num_q[6:0];
					rsp_d.block_order  = order_q[2:0];
					state_d            = S_DONE;
				end
			end

			S_F_TOP: begin
				if (order_q >= MAXO_L || {1'b0, buddy} >= NUM_L) begin
					state_d = S_F_LINK;
				end else begin
					buddy_d   = buddy;
					cmd.rd_en = 1'b1;
					addr      = buddy[AW-1:0];
					state_d   = S_F_BCHK;
				end
			end

			S_F_BCHK: begin
				if (rdata == BUSY_LINK) begin
					state_d = S_F_LINK;
				end else if (head_rd == buddy_q) begin
					// buddy heads its list; its successor is known not busy
					hw_en     = 1'b1;
					hw_data   = rdata;
					cmd.wr_en = 1'b1;
					cmd.wdata = NIL_LINK;
					addr      = buddy_q[AW-1:0];
					if (buddy_q < num_q) begin
						num_d = buddy_q;
					end
					order_d = order_q + 5'd1;
					state_d = S_F_TOP;
				end else begin
					prev_d     = head_rd;
					bud_link_d = rdata;
					steps_d    = '0;
					state_d    = S_F_WALK;
				end
			end

			S_F_WALK: begin
				if (prev_q == NIL_LINK) begin
					state_d = S_F_LINK;
				end else if ({1'b0, prev_q} >= NUM_L) begin
					rsp_d.status = ST_CORRUPT;
					state_d      = S_DONE;
				end else begin
					cmd.rd_en = 1'b1;
					addr      = prev_q[AW-1:0];
					state_d   = S_F_WCHK;
				end
			end

			S_F_WCHK: begin
				if (rdata == buddy_q) begin
					// unlink buddy from the middle of the list
					cmd.wr_en = 1'b1;
					cmd.wdata = bud_link_q;
					addr      = prev_q[AW-1:0];
					if (buddy_q < num_q) begin
						num_d = buddy_q;
					end
					order_d = order_q + 5'd1;
					state_d = S_F_TOP;
				end else begin
					prev_d  = rdata;
					steps_d = steps_inc;
					if (steps_inc > STEP_LIM) begin
						rsp_d.status = ST_CORRUPT;
						state_d      = S_DONE;
					end else begin
						state_d = S_F_WALK;
					end
				end
			end

			S_F_LINK: begin
				cmd.wr_en = 1'b1;
				cmd.wdata = head_rd;
				hw_en     = 1'b1;
				state_d   = S_DONE;
			end

			S_DONE: begin
				if (take) begin
					state_d = S_IDLE;
				end
			end

			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			for (int i = 0; i <= int'(MAX_ORDER); i++) begin
				if (LOW_OK && i == int'(LOW_ORDER)) begin
					heads_q[i] <= LINK_W'(LOW_BLOCK);
				end else if (HIGH_OK && i == int'(HIGH_ORDER)) begin
					heads_q[i] <= LINK_W'(HIGH_BLOCK);
				end else begin
					heads_q[i] <= NIL_LINK;
				end
			end
		end else begin
			state_q <= state_d;
			if (hw_en) begin
				heads_q[hw_idx] <= hw_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		ctx_q      <= ctx_d;
		order_q    <= order_d;
		slot_q     <= slot_d;
		num_q      <= num_d;
		buddy_q    <= buddy_d;
		bud_link_q <= bud_link_d;
		prev_q     <= prev_d;
		steps_q    <= steps_d;
		rsp_q      <= rsp_d;
	end

	assign idle = (state_q == S_IDLE);
	assign done = (state_q == S_DONE);
	assign rsp  = rsp_q;

endmodule

`default_nettype wire

// File: rtl/buddy_context_allocator.sv
// buddy_context_allocator: top level with request/response handshake,
// limit register and output register; depends on bca_pkg, bca_seq, bca_link_ram
`default_nettype none

// Buddy allocator over NUM_CONTEXTS MMU contexts. An allocate request rounds
// its page count up to contexts and a power-of-two order, pops the first free
// block at that order or above and returns the split-off halves to the lower
// lists. A free request merges with free buddies order by order, walking each
// free list to unlink the buddy, then links the merged block. One request is
// worked on at a time; in_ready is high only while the sequencer is idle, and
// a finished response waits in the output register without holding up the
// next request. The single link-memory port does one read or write per
// cycle. An allocate takes longer with a higher order, with each list
// searched and with each split; a free takes longer with each merge step
// and each list element walked, and ends by linking the result. A too-big
// or out-of-range request goes straight to the response. No clearing pass
// after reset: the link map tracks written entries and reads the reset
// contents otherwise.
module buddy_context_allocator import bca_pkg::*; #(
	parameter int unsigned NUM_CONTEXTS           = NUM_CONTEXTS_DEF,
	parameter int unsigned MAX_ORDER              = MAX_ORDER_DEF,
	parameter int unsigned PAGES_PER_CONTEXT_LOG2 = PAGES_PER_CONTEXT_LOG2_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire req_t        in_data,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      rsp_t        out_data,
	input  wire logic        cfg_wr_en,
	input  wire logic [15:0] cfg_wr_data
);

	localparam int unsigned AW = $clog2(NUM_CONTEXTS);

	// whole-map limit register
	logic [15:0] limit_q;

	// sequencer handshake
	logic        seq_idle;
	logic        seq_done;
	logic        seq_take;
	rsp_t        seq_rsp;

	// link memory port
	lm_cmd_t           lm_cmd;
	logic [AW-1:0]     lm_addr;
	logic [LINK_W-1:0] lm_rdata;

	// output register
	logic out_valid_q;
	rsp_t out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			limit_q <= WHOLE_MAP_LIMIT_RST;
		end else if (cfg_wr_en) begin
			limit_q <= cfg_wr_data;
		end
	end

	// a request is taken only while the sequencer is idle
	assign in_ready = seq_idle;

	// the output register frees up when empty or being drained
	assign seq_take = !out_valid_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (seq_done && seq_take) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done && seq_take) begin
			out_data_q <= seq_rsp;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	bca_seq #(
		.NUM_CONTEXTS           (NUM_CONTEXTS),
		.MAX_ORDER              (MAX_ORDER),
		.PAGES_PER_CONTEXT_LOG2 (PAGES_PER_CONTEXT_LOG2)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (in_valid && seq_idle),
		.req    (in_data),
		.limit  (limit_q),
		.idle   (seq_idle),
		.done   (seq_done),
		.rsp    (seq_rsp),
		.take   (seq_take),
		.cmd    (lm_cmd),
		.addr   (lm_addr),
		.rdata  (lm_rdata)
	);

	bca_link_ram #(
		.DEPTH     (NUM_CONTEXTS),
		.MAX_ORDER (MAX_ORDER)
	) u_link_ram (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (lm_cmd),
		.addr   (lm_addr),
		.rdata  (lm_rdata)
	);

endmodule

`default_nettype wire

// File: sim/tb.sv
`timescale 1ns / 100ps
// tb: self-checking bench for buddy_context_allocator; keeps a shadow copy of the
// free lists and link map to predict every response; depends on bca_pkg and the rtl
module tb;
	import bca_pkg::*;

	localparam int unsigned CTX_COUNT   = NUM_CONTEXTS_DEF;
	localparam int unsigned ORDER_CAP   = MAX_ORDER_DEF;
	localparam int unsigned PAGE_SHIFT  = PAGES_PER_CONTEXT_LOG2_DEF;
	localparam int unsigned STALL_LIMIT = 40000;
	localparam int unsigned HELD_CAP    = 24;
	localparam logic [2:0]  ORDER_OUT_OF_RANGE = 3'd7;

	// one block handed out and not yet returned
	typedef struct packed {
		logic [6:0] blk;
		logic [2:0] ord;
	} held_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	req_t        in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rsp_t        out_data;
	logic        cfg_wr_en = 1'b0;
	logic [15:0] cfg_wr_data = '0;

	// shadow of the allocator state
	logic [LINK_W-1:0] shadow_link [0:CTX_COUNT];
	logic [LINK_W-1:0] shadow_head [0:ORDER_CAP];
	logic [15:0]       shadow_limit;

	rsp_t        outcomes_due[$];   // responses owed, oldest first
	held_t       held[$];           // blocks allocated during random traffic
	held_t       last_freed;
	bit          have_last = 1'b0;
	bit          track_held = 1'b0;
	int unsigned sender_idle_pct = 0;
	int unsigned receiver_stall_pct = 0;
	int unsigned mismatch_count = 0;
	int unsigned quiet_cycles = 0;

	buddy_context_allocator DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_data    (in_data),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	// power-up layout: 32 contexts free at 0, 64 free at 0x40, 0x20-0x3f busy
	function automatic void reset_shadow();
		for (int unsigned i = 0; i <= CTX_COUNT; i++)
			shadow_link[i] = BUSY_LINK;
		for (int unsigned i = 0; i <= ORDER_CAP; i++)
			shadow_head[i] = NIL_LINK;
		shadow_head[LOW_ORDER]  = LINK_W'(LOW_BLOCK);
		shadow_link[LOW_BLOCK]  = NIL_LINK;
		shadow_head[HIGH_ORDER] = LINK_W'(HIGH_BLOCK);
		shadow_link[HIGH_BLOCK] = NIL_LINK;
		shadow_limit = WHOLE_MAP_LIMIT_RST;
	endfunction

	// allocate: round pages to contexts and to an order, pop the first
	// non-empty list at or above it, hand the upper halves back down
	function automatic rsp_t carve_block(input logic [15:0] pages);
		rsp_t        r;
		int unsigned ctx, want, slot, head, num, half;
		r = '0;
		if (pages > shadow_limit) begin
			r.status = ST_TOO_BIG;
			return r;
		end
		ctx = (int'(pages) + (1 << PAGE_SHIFT) - 1) >> PAGE_SHIFT;
		want = 0;
		while (want < 31 && (1 << want) < ctx)
			want++;
		r.status = ST_NO_FREE;
		for (slot = want; slot < ORDER_CAP; slot++) begin
			head = shadow_head[slot];
			if (head == NIL_LINK)
				continue;
			// head outside the map, or block running off its end
			if (head >= CTX_COUNT || head + (1 << slot) > CTX_COUNT) begin
				r.status = ST_CORRUPT;
				return r;
			end
			num = head;
			shadow_head[slot] = shadow_link[num];
			while (slot > want) begin
				slot--;
				half = 1 << slot;
				shadow_link[num + half] = shadow_head[slot];
				shadow_head[slot] = LINK_W'(num + half);
			end
			shadow_link[num] = BUSY_LINK;
			r.status = ST_OK;
			r.block_number = 7'(num);
			r.block_order = 3'(want);
			return r;
		end
		return r;
	endfunction

	// free: merge with free buddies one order at a time, then link the result
	function automatic rsp_t merge_block(input logic [6:0] blk, input logic [2:0] ord);
		rsp_t        r;
		int unsigned num, order, buddy, prev, steps;
		r = '0;
		num = blk;
		order = ord;
		if (num >= CTX_COUNT || order >= ORDER_CAP)
			return r;
		while (order < ORDER_CAP) begin
			buddy = num ^ (1 << order);
			if (buddy >= CTX_COUNT || shadow_link[buddy] == BUSY_LINK)
				break;
			if (shadow_head[order] == buddy) begin
				shadow_head[order] = shadow_link[buddy];
				shadow_link[buddy] = NIL_LINK;
				if (shadow_head[order] == BUSY_LINK) begin
					r.status = ST_CORRUPT;
					return r;
				end
			end else begin
				// walk the list for the element pointing at the buddy
				prev = shadow_head[order];
				steps = 0;
				while (prev != NIL_LINK) begin
					if (prev >= CTX_COUNT) begin
						r.status = ST_CORRUPT;
						return r;
					end
					if (shadow_link[prev] == buddy)
						break;
					prev = shadow_link[prev];
					steps++;
					if (steps > CTX_COUNT + 1) begin
						r.status = ST_CORRUPT;
						return r;
					end
				end
				if (prev == NIL_LINK)
					break;
				shadow_link[prev] = shadow_link[buddy];
			end
			if (buddy < num)
				num = buddy;
			order++;
		end
		shadow_link[num] = shadow_head[order];
		shadow_head[order] = LINK_W'(num);
		return r;
	endfunction

	// random request: mostly alloc/free pairs over blocks we really hold,
	// some out-of-range noise, and in the broken mix wild and double frees
	function automatic req_t pick_request(input int unsigned noise_pct,
			input int unsigned broken_pct);
		req_t        r;
		held_t       h;
		int unsigned roll, o, k;
		r.opcode = 1'($urandom);
		r.request_pages = 16'($urandom);
		r.free_block = 7'($urandom);
		r.free_order = 3'($urandom);
		roll = $urandom_range(0, 99);
		if (roll < broken_pct) begin
			r.opcode = OP_FREE;
			if (have_last && $urandom_range(0, 2) == 0) begin
				r.free_block = last_freed.blk;
				r.free_order = last_freed.ord;
			end
			return r;
		end
		if (roll < broken_pct + noise_pct) begin
			// full-range page count, or a free the block ignores
			if (r.opcode == OP_FREE)
				r.free_order = ORDER_OUT_OF_RANGE;
			return r;
		end
		if (held.size() == 0 || (held.size() < HELD_CAP && $urandom_range(0, 1) == 0)) begin
			// small orders most of the time so the lists split and merge a lot
			o = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 3) : $urandom_range(4, 6);
			r.opcode = OP_ALLOC;
			r.request_pages = 16'($urandom_range(0, 1 << (o + PAGE_SHIFT)));
		end else begin
			k = $urandom_range(0, held.size() - 1);
			h = held[k];
			held.delete(k);
			r.opcode = OP_FREE;
			r.free_block = h.blk;
			r.free_order = h.ord;
			last_freed = h;
			have_last = 1'b1;
		end
		return r;
	endfunction

	// one request through the input handshake; the outcome is predicted
	// at the edge where it is taken
	task automatic send_request(input req_t r);
		rsp_t due;
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= r;
		do
			@(posedge clk);
		while (!in_ready);
		if (r.opcode == OP_ALLOC)
			due = carve_block(r.request_pages);
		else
			due = merge_block(r.free_block, r.free_order);
		outcomes_due.push_back(due);
		if (track_held && r.opcode == OP_ALLOC && due.status == ST_OK)
			held.push_back({due.block_number, due.block_order});
	endtask

	task automatic ask_alloc(input logic [15:0] pages);
		req_t r;
		r = {1'($urandom), 16'($urandom), 7'($urandom), 3'($urandom)};
		r.opcode = OP_ALLOC;
		r.request_pages = pages;
		send_request(r);
	endtask

	task automatic ask_free(input logic [6:0] blk, input logic [2:0] ord);
		req_t r;
		r = {1'($urandom), 16'($urandom), 7'($urandom), 3'($urandom)};
		r.opcode = OP_FREE;
		r.free_block = blk;
		r.free_order = ord;
		send_request(r);
	endtask

	// stop sending and wait for every owed response, then idle with no traffic
	task automatic settle();
		in_valid <= 1'b0;
		@(posedge clk);
		while (outcomes_due.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// only called once settled, so no request is in flight
	task automatic write_limit(input logic [15:0] value);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		shadow_limit = value;
	endtask

	task automatic run_traffic(input int unsigned count, input int unsigned s_pct,
			input int unsigned r_pct, input int unsigned noise_pct,
			input int unsigned broken_pct);
		sender_idle_pct = s_pct;
		receiver_stall_pct = r_pct;
		repeat (count)
			send_request(pick_request(noise_pct, broken_pct));
		settle();
	endtask

	// splitting the reset layout down to order 0 and merging it back
	task automatic test_split_and_merge();
		sender_idle_pct = 0;
		receiver_stall_pct = 0;
		ask_alloc(16'd0);       // zero pages still takes one context
		ask_alloc(16'd16);      // exactly one context
		ask_alloc(16'd17);      // one page over rounds to order 1
		ask_free(7'd1, 3'd0);
		ask_free(7'd0, 3'd0);   // buddy at the head of its list
		ask_free(7'd2, 3'd1);   // merges all the way back to order 5
		ask_alloc(16'd1024);    // at the limit, whole upper half
		settle();
	endtask

	// too big, exhaustion, order past the top, ignored frees
	task automatic test_limit_and_exhaustion();
		ask_alloc(16'd1025);
		ask_alloc(16'd1024);    // order 6 list now empty
		settle();
		write_limit(16'hFFFF);
		ask_alloc(16'hFFFF);    // rounds far beyond the top order
		ask_alloc(16'd1025);    // rounds to exactly the top order
		ask_free(7'h7F, ORDER_OUT_OF_RANGE);
		ask_free(7'h00, ORDER_OUT_OF_RANGE);
		ask_free(7'h40, 3'd6);
		settle();
	endtask

	// returning the reserved block merges the whole map into one top-order
	// block that is never handed out; freeing its halves carves it back
	task automatic test_merge_to_top();
		ask_free(7'h20, 3'd5);
		ask_alloc(16'd0);
		ask_free(7'h40, 3'd6);
		ask_free(7'h20, 3'd5);
		ask_alloc(16'd512);
		ask_alloc(16'd16);
		ask_free(7'h20, 3'd5);
		ask_free(7'h40, 3'd0);
		settle();
	endtask

	// alloc/free traffic with some out-of-range noise under every idling mix
	task automatic test_steady_traffic();
		track_held = 1'b1;
		run_traffic(400, 0, 0, 8, 0);
		write_limit(WHOLE_MAP_LIMIT_RST);
		run_traffic(400, 49, 0, 8, 0);
		write_limit(16'($urandom_range(200, 2000)));
		run_traffic(400, 0, 49, 8, 0);
		write_limit(16'($urandom_range(2, 65534)));
		run_traffic(300, 28, 28, 8, 0);
	endtask

	// limit of one page: almost every allocate is too big
	task automatic test_tight_limit();
		write_limit(16'd1);
		run_traffic(60, 28, 28, 8, 0);
	endtask

	// double, misaligned and wild frees; lists may end up corrupt
	task automatic test_broken_frees();
		write_limit(16'hFFFF);
		run_traffic(150, 28, 28, 5, 40);
	endtask

	initial begin
		reset_shadow();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_split_and_merge();
		test_limit_and_exhaustion();
		test_merge_to_top();
		test_steady_traffic();
		test_tight_limit();
		test_broken_frees();
		settle();
		repeat (16) @(posedge clk);
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// receiver back-pressure
	always @(posedge clk) begin
		out_ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
	end

	// compare each response taken with the oldest one owed
	always @(posedge clk) begin : check_responses
		rsp_t due;
		if (arst_n && out_valid && out_ready) begin
			if (outcomes_due.size() == 0) begin
				$error("response with no request outstanding: status %0d block %0d order %0d",
					out_data.status, out_data.block_number, out_data.block_order);
				mismatch_count++;
			end else begin
				due = outcomes_due.pop_front();
				if (out_data.status !== due.status) begin
					$error("status expected %0d got %0d", due.status, out_data.status);
					mismatch_count++;
				end
				if (out_data.block_number !== due.block_number) begin
					$error("block_number expected %0d got %0d",
						due.block_number, out_data.block_number);
					mismatch_count++;
				end
				if (out_data.block_order !== due.block_order) begin
					$error("block_order expected %0d got %0d",
						due.block_order, out_data.block_order);
					mismatch_count++;
				end
			end
		end
	end

	// even a long free walk ends well before this much silence, so it means a hang
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= STALL_LIMIT) begin
			$display("simulation failed");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

endmodule

// File: filelist.f
rtl/bca_pkg.sv
rtl/bca_link_ram.sv
rtl/bca_seq.sv
rtl/buddy_context_allocator.sv
sim/tb.sv
